@@ design/rgb565_per_channel_biquad_filter_defines.svh @@
// Assertion macros shared by the filter RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RGB565_PER_CHANNEL_BIQUAD_FILTER_DEFINES_SVH
`define RGB565_PER_CHANNEL_BIQUAD_FILTER_DEFINES_SVH

// Same-cycle implication.
`define RGBBQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbbq: assertion failed");

// Next-cycle implication.
`define RGBBQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbbq: assertion failed");

`endif

@@ design/rgbbq_pkg.sv @@
package rgbbq_pkg;

  localparam int PIX_W     = 16;
  localparam int CH_W      = 8;
  localparam int REG_W     = 60;
  localparam int REG_IDX_W = 2;
  localparam int FRAC_BITS = 8;
  localparam int W_BITS    = 16;

  typedef logic [REG_W-1:0] coef_reg_t;
  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CH_W-1:0]  chan_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_W  = 2'd0,
    PH_B0 = 2'd1,
    PH_Y  = 2'd2
  } phase_t;

  typedef struct packed {
    logic   start;
    logic   step;
    phase_t phase;
  } lane_ctl_t;

endpackage

@@ design/rgbbq_in_if.sv @@
interface rgbbq_in_if;
  import rgbbq_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

@@ design/rgbbq_out_if.sv @@
interface rgbbq_out_if;
  import rgbbq_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface

@@ design/rgbbq_lane.sv @@
module rgbbq_lane #(
  parameter int COEF_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rgbbq_pkg::lane_ctl_t  ctl,
  input  rgbbq_pkg::coef_reg_t  coef,
  input  rgbbq_pkg::chan_t      x_in,
  output rgbbq_pkg::chan_t      y_out
);
  import rgbbq_pkg::*;

  localparam int PW    = COEF_BITS + W_BITS;
  localparam int AW    = COEF_BITS + W_BITS + 2;
  localparam int QW    = AW - FRAC_BITS;
  localparam int EXT_W = (5 * COEF_BITS > REG_W) ? 5 * COEF_BITS : REG_W;

  logic [EXT_W-1:0]            coef_ext;
  logic signed [COEF_BITS-1:0] b0, b1, b2, a1, a2;
  logic signed [COEF_BITS-1:0] c0, c1;
  logic signed [W_BITS-1:0]    d0;
  logic signed [PW-1:0]        m0, m1;

  logic signed [W_BITS-1:0] w1_r, w2_r;
  logic signed [W_BITS-1:0] w_r, w_nxt;
  chan_t                    x_r;
  logic signed [PW-1:0]     pa_r, pb_r, pc_r;
  logic signed [AW-1:0]     ps_r;

  logic signed [AW-1:0] acc_w, acc_y;
  logic [QW-1:0]        q_w;
  logic                 pos_ovf, neg_ovf;

  assign coef_ext = EXT_W'(coef);
  assign b0 = coef_ext[0*COEF_BITS +: COEF_BITS];
  assign b1 = coef_ext[1*COEF_BITS +: COEF_BITS];
  assign b2 = coef_ext[2*COEF_BITS +: COEF_BITS];
  assign a1 = coef_ext[3*COEF_BITS +: COEF_BITS];
  assign a2 = coef_ext[4*COEF_BITS +: COEF_BITS];

  always_comb begin
    priority if (ctl.start) begin
      c0 = a1;
      d0 = w1_r;
      c1 = a2;
    end else if (ctl.phase == PH_W) begin
      c0 = b1;
      d0 = w1_r;
      c1 = b2;
    end else begin
      c0 = b0;
      d0 = w_r;
      c1 = b2;
    end
  end

  assign m0 = c0 * d0;
  assign m1 = c1 * w2_r;

  // Feedback value: (x*256 - a1*w1 - a2*w2) / 256 toward zero, saturated.
  assign acc_w = AW'($signed({1'b0, x_r, 8'h00})) - AW'(pa_r) - AW'(pb_r);
  assign q_w   = acc_w[AW-1:FRAC_BITS] +
                 QW'(acc_w[AW-1] && (|acc_w[FRAC_BITS-1:0]));
  assign pos_ovf = !q_w[QW-1] && (|q_w[QW-2:W_BITS-1]);
  assign neg_ovf = q_w[QW-1] && !(&q_w[QW-2:W_BITS-1]);

  always_comb begin
    priority if (pos_ovf) begin
      w_nxt = 16'sh7FFF;
    end else if (neg_ovf) begin
      w_nxt = -16'sh8000;
    end else begin
      w_nxt = q_w[W_BITS-1:0];
    end
  end

  // Output value, only its low byte is kept.
  assign acc_y = AW'(pc_r) + ps_r;
  assign y_out = acc_y[FRAC_BITS +: CH_W] +
                 CH_W'(acc_y[AW-1] && (|acc_y[FRAC_BITS-1:0]));

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r  <= x_in;
      pa_r <= m0;
      pb_r <= m1;
    end else if (ctl.step) begin
      unique case (ctl.phase)
        PH_W: begin
          w_r  <= w_nxt;
          pa_r <= m0;
          pb_r <= m1;
        end
        PH_B0: begin
          pc_r <= m0;
          ps_r <= AW'(pa_r) + AW'(pb_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r <= '0;
      w2_r <= '0;
    end else if (ctl.step && ctl.phase == PH_B0) begin
      w2_r <= w1_r;
      w1_r <= w_r;
    end
  end

endmodule

@@ design/rgbbq_merge.sv @@
module rgbbq_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  rgbbq_pkg::chan_t  y_red,
  input  rgbbq_pkg::chan_t  y_green,
  input  rgbbq_pkg::chan_t  y_blue,
  output logic              free,
  rgbbq_out_if.source       out_ch
);
  import rgbbq_pkg::*;

  logic   valid_r;
  pixel_t pixel_r;

  assign free             = !valid_r || out_ch.ready;
  assign out_ch.valid     = valid_r;
  assign out_ch.pixel_out = pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r <= {y_red[7:3], y_green[7:2], y_blue[7:3]};
    end
  end

endmodule

@@ design/rgb565_per_channel_biquad_filter.sv @@
// RGB565 per-channel biquad filter.
// in_ch takes one RGB565 word per handshake; out_ch returns one filtered RGB565
// word for every input word, in order. Each channel is widened to 8 bits and
// runs through its own direct form II second-order section in a lane of its
// own; the three lane results are packed into the output register.
// Coefficients are written on cfg_we/cfg_index/cfg_data: index 0 red,
// 1 green, 2 blue, five signed COEF_BITS fields b0, b1, b2, a1, a2 from bit 0
// up. Write them only while the filter is idle.
// A word accepted on in_ch passes the sequencer phases PH_W, PH_B0 and PH_Y,
// which walk each lane's two multipliers through the feedback products, the
// saturated state value and the b0 product, and then goes to the output register.
// in_ch.ready stays low until then, so no new word is taken while one is busy.
// Reset loads b0 = 1.0 and all other coefficients with zero for every
// channel, clears the filter state and empties the output register.
// When out_ch stalls, the finished word holds in the lanes, in_ch.ready stays
// low and the filter state does not advance until the output register frees.
`include "rgb565_per_channel_biquad_filter_defines.svh"

module rgb565_per_channel_biquad_filter #(
  parameter int COEF_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rgbbq_in_if.sink                     in_ch,
  rgbbq_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [rgbbq_pkg::REG_IDX_W-1:0] cfg_index,
  input  rgbbq_pkg::coef_reg_t         cfg_data
);
  import rgbbq_pkg::*;

  coef_reg_t coef_red_r, coef_green_r, coef_blue_r;
  logic      busy_r;
  phase_t    phase_r;
  logic      in_fire, free, done, step;
  lane_ctl_t ctl;
  chan_t     r8, g8, b8;
  chan_t     yr, yg, yb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_red_r   <= REG_W'(256);
      coef_green_r <= REG_W'(256);
      coef_blue_r  <= REG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED:   coef_red_r   <= cfg_data;
        REG_GREEN: coef_green_r <= cfg_data;
        REG_BLUE:  coef_blue_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !busy_r;
  assign in_fire     = in_ch.valid && !busy_r;
  assign done        = busy_r && phase_r == PH_Y && free;
  assign step        = busy_r && (phase_r != PH_Y || free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_W;
    end else if (in_fire) begin
      busy_r  <= 1'b1;
      phase_r <= PH_W;
    end else if (step) begin
      unique case (phase_r)
        PH_W:  phase_r <= PH_B0;
        PH_B0: phase_r <= PH_Y;
        PH_Y:  busy_r  <= 1'b0;
        default: phase_r <= PH_W;
      endcase
    end
  end

  assign ctl.start = in_fire;
  assign ctl.step  = step;
  assign ctl.phase = phase_r;

  assign r8 = {in_ch.pixel_in[15:11], 3'b000};
  assign g8 = {in_ch.pixel_in[10:5], 2'b00};
  assign b8 = {in_ch.pixel_in[4:0], 3'b000};

  rgbbq_lane #(.COEF_BITS(COEF_BITS)) u_lane_red (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .coef  (coef_red_r),
    .x_in  (r8),
    .y_out (yr)
  );

  rgbbq_lane #(.COEF_BITS(COEF_BITS)) u_lane_green (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .coef  (coef_green_r),
    .x_in  (g8),
    .y_out (yg)
  );

  rgbbq_lane #(.COEF_BITS(COEF_BITS)) u_lane_blue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .coef  (coef_blue_r),
    .x_in  (b8),
    .y_out (yb)
  );

  rgbbq_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (done),
    .y_red   (yr),
    .y_green (yg),
    .y_blue  (yb),
    .free    (free),
    .out_ch  (out_ch)
  );

  `RGBBQ_ASSERT_NXT(a_accept_starts, in_fire, busy_r && phase_r == PH_W)
  `RGBBQ_ASSERT_NXT(a_w_advances, busy_r && phase_r == PH_W, busy_r && phase_r == PH_B0)
  `RGBBQ_ASSERT_NXT(a_done_loads, done, out_ch.valid && !busy_r)
  `RGBBQ_ASSERT_NXT(a_stall_holds, busy_r && phase_r == PH_Y && !free, busy_r && phase_r == PH_Y)

endmodule

@@ sim/rgb565_per_channel_biquad_filter_tb.sv @@
module rgb565_per_channel_biquad_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbbq_pkg::*;

  localparam int COEF_BITS = 12;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  coef_reg_t cfg_data;

  rgbbq_in_if in_bus ();
  rgbbq_out_if out_bus ();

  rgb565_per_channel_biquad_filter #(
    .COEF_BITS(COEF_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  coef_reg_t coef_bank [3];
  longint lane_w1 [3];
  longint lane_w2 [3];
  pixel_t pending_pixels [$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int gap_pct = 20;
  int stall_pct = 10;
  bit idle_en = 1'b1;

  always #5 clk = ~clk;

  function automatic longint coef_at(input coef_reg_t r, input int k);
    logic [COEF_BITS-1:0] raw;
    raw = '0;
    for (int b = 0; b < COEF_BITS; b++) begin
      if (k * COEF_BITS + b < REG_W) raw[b] = r[k * COEF_BITS + b];
    end
    return longint'(signed'(raw));
  endfunction

  // One direct form II section; the state holds w, not past inputs.
  function automatic chan_t filter_lane(input int lane, input chan_t x);
    longint b0, b1, b2, a1, a2, xv, acc, w, y;
    b0 = coef_at(coef_bank[lane], 0);
    b1 = coef_at(coef_bank[lane], 1);
    b2 = coef_at(coef_bank[lane], 2);
    a1 = coef_at(coef_bank[lane], 3);
    a2 = coef_at(coef_bank[lane], 4);
    xv = x;
    acc = xv * 256 - a1 * lane_w1[lane] - a2 * lane_w2[lane];
    w = acc / 256;
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    y = (b0 * w + b1 * lane_w1[lane] + b2 * lane_w2[lane]) / 256;
    lane_w2[lane] = lane_w1[lane];
    lane_w1[lane] = w;
    return y[7:0];
  endfunction

  function automatic pixel_t predict_pixel(input pixel_t pix);
    chan_t yr, yg, yb;
    yr = filter_lane(REG_RED, {pix[15:11], 3'b000});
    yg = filter_lane(REG_GREEN, {pix[10:5], 2'b00});
    yb = filter_lane(REG_BLUE, {pix[4:0], 3'b000});
    return {yr[7:3], yg[7:2], yb[7:3]};
  endfunction

  function automatic coef_reg_t pack_coefs(input int b0, input int b1, input int b2,
                                           input int a1, input int a2);
    return {a2[COEF_BITS-1:0], a1[COEF_BITS-1:0], b2[COEF_BITS-1:0],
            b1[COEF_BITS-1:0], b0[COEF_BITS-1:0]};
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return 2047;
      1: return -2048;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic coef_reg_t random_coefs();
    case ($urandom_range(0, 3))
      0: return pack_coefs($urandom_range(0, 512) - 256, $urandom_range(0, 512) - 256,
                           $urandom_range(0, 512) - 256, $urandom_range(0, 768) - 384,
                           $urandom_range(0, 400) - 200);
      1: return REG_W'({$urandom, $urandom});
      2: return pack_coefs(pick_extreme(), pick_extreme(), pick_extreme(),
                           pick_extreme(), pick_extreme());
      default: return pack_coefs(256, 0, 0, $urandom_range(0, 256) - 128,
                                 $urandom_range(0, 128) - 64);
    endcase
  endfunction

  task automatic note_failure(input string what, input pixel_t want, input pixel_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t: %s: expected pixel_out 0x%04h, got 0x%04h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        note_failure("word with nothing expected", 'x, out_bus.pixel_out);
      end else if (out_bus.pixel_out !== pending_pixels[0]) begin
        note_failure("mismatch", pending_pixels[0], out_bus.pixel_out);
        void'(pending_pixels.pop_front());
      end else begin
        void'(pending_pixels.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 99) < stall_pct) begin
      out_bus.ready <= 1'b0;
      stall_left <= $urandom_range(1, 18) - 1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_pixel(input pixel_t pix);
    if (idle_en && $urandom_range(0, 99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.pixel_in <= pix;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_pixels.push_back(predict_pixel(pix));
  endtask

  task automatic drain_filter();
    in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // The write to the unused index must leave all three banks untouched.
  task automatic program_filter(input coef_reg_t red, input coef_reg_t green,
                                input coef_reg_t blue);
    coef_reg_t vals [3];
    vals[REG_RED] = red;
    vals[REG_GREEN] = green;
    vals[REG_BLUE] = blue;
    drain_filter();
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      coef_bank[i] = vals[i];
    end
    cfg_index <= REG_UNUSED;
    cfg_data <= REG_W'({$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_passthrough_reset();
    pixel_t pix [6] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hA5A5};
    foreach (pix[i]) send_pixel(pix[i]);
  endtask

  task automatic test_coef_extremes();
    coef_reg_t all_max, all_min;
    all_max = pack_coefs(2047, 2047, 2047, 2047, 2047);
    all_min = pack_coefs(-2048, -2048, -2048, -2048, -2048);
    program_filter(all_max, all_min, '0);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h5555);
    program_filter(all_min, '0, all_max);
    send_pixel(16'hFFFF);
    send_pixel(16'hAAAA);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    program_filter({REG_W{1'b1}}, all_max, all_min);
    send_pixel(16'h0821);
    send_pixel(16'hF7DE);
    send_pixel(16'hFFFF);
  endtask

  task automatic test_random_filters();
    for (int phase = 0; phase < 8; phase++) begin
      program_filter(random_coefs(), random_coefs(), random_coefs());
      idle_en = ($urandom_range(0, 3) != 0);
      gap_pct = $urandom_range(0, 40);
      stall_pct = $urandom_range(0, 30);
      repeat ($urandom_range(30, 60)) begin
        send_pixel(pixel_t'($urandom_range(0, 65535)));
        if ($urandom_range(0, 59) == 0) drain_filter();
      end
    end
  endtask

  task automatic test_back_to_back();
    program_filter(random_coefs(), random_coefs(), random_coefs());
    idle_en = 1'b0;
    repeat (40) send_pixel(pixel_t'($urandom_range(0, 65535)));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RED;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.pixel_in = '0;
    for (int i = 0; i < 3; i++) begin
      coef_bank[i] = REG_W'(256);
      lane_w1[i] = 0;
      lane_w2[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough_reset();
    test_coef_extremes();
    test_random_filters();
    test_back_to_back();

    drain_filter();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
